// ===== hdl/f2sf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2sf_pkg: shared types and constants of the float32 to small-float converter
// Target format codes, exponent limits and the canonical special values.
// ----------------------------------------------------------------------------
package f2sf_pkg;

   // target format, carried in tuser
   typedef enum logic [1:0] {
      FMT_HALF = 2'd0,
      FMT_F11  = 2'd1,
      FMT_F10  = 2'd2
   } fmt_type;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned RESULT_W = 16;

   // float32 exponent limits; small formats share bias 15
   localparam logic [7:0] EXP_ZERO   = 8'h00;
   localparam logic [7:0] EXP_SPEC   = 8'hff;
   localparam logic [7:0] EXP_OFFSET = 8'd112;       // 127 - 15
   localparam logic [7:0] EXP_MAX    = 8'd142;       // 127 + 15

   // round-bit position of a denormal result: (23 - mb - 1) + 113
   localparam logic [7:0] DN_SHIFT_HALF = 8'd125;
   localparam logic [7:0] DN_SHIFT_F11  = 8'd129;
   localparam logic [7:0] DN_SHIFT_F10  = 8'd130;

   // canonical specials
   localparam logic [15:0] NAN_HALF = 16'h7e00;
   localparam logic [15:0] NAN_F11  = 16'h07e0;
   localparam logic [15:0] NAN_F10  = 16'h03f0;
   localparam logic [15:0] INF_HALF = 16'h7c00;
   localparam logic [15:0] INF_F11  = 16'h07c0;
   localparam logic [15:0] INF_F10  = 16'h03e0;

endpackage

// ===== hdl/float32_to_small_float.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_to_small_float: float32 to half / float11 / float10 converter
// Rounds to nearest (ties away), flushes float32 denormals, denormalises
// small results and maps specials to canonical codes.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------
//  req     | in  | req_tvalid/req_tready | tdata: value_bits, tuser: cmd
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: result_bits
//
//  One item per cycle sustained while rsp_tready is held high; rsp_tvalid
//  rises once an accepted item has passed from the input register through
//  one conversion pass into the result register.
//  The conversion is a single combinational pass: an exponent compare, a
//  rounding add and a barrel shift for denormal results.
//  Synchronous active-high reset empties both stages; payload is not reset.
//  A stalled result holds in the output register; the input stage keeps
//  accepting as long as the item ahead of it can move on.
// ----------------------------------------------------------------------------
module float32_to_small_float
   import f2sf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VALUE_W-1:0]    req_tdata,   // [31:0] value_bits
   input  logic [1:0]            req_tuser,   // [1:0] cmd
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RESULT_W-1:0]   rsp_tdata    // [15:0] result_bits
);

   // ---------------- pipeline control ----------------
   logic                s1_valid_ff, s1_valid_in;
   fmt_type             s1_cmd_ff;
   logic [VALUE_W-1:0]  s1_value_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0] rsp_data_ff;

   logic req_accept;
   logic rsp_free;     // output register can take an item this cycle
   logic s1_adv;       // input stage hands its item on

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && rsp_free;
   assign req_tready = !s1_valid_ff || rsp_free;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- conversion ----------------
   logic                sign;
   logic [7:0]          expo;
   logic [22:0]         mant;
   logic [23:0]         full;       // mantissa with hidden one
   logic [4:0]          ex_n;       // rebiased exponent, normal results
   logic [14:0]         norm_mag;   // exponent|mantissa plus round; carry lands in exponent
   logic [7:0]          dn_shift;
   logic [23:0]         dn_bits;    // result mantissa with round bit at bit 0
   logic [14:0]         dn_mag;
   logic                signed_fmt;
   logic                known_fmt;
   logic [15:0]         nan_code;
   logic [15:0]         inf_code;
   logic [15:0]         sgn_bit;
   logic [RESULT_W-1:0] result_in;

   always_comb begin
      sign       = s1_value_ff[31];
      expo       = s1_value_ff[30:23];
      mant       = s1_value_ff[22:0];
      full       = {1'b1, mant};
      ex_n       = 5'(expo - EXP_OFFSET);
      norm_mag   = '0;
      dn_shift   = '0;
      signed_fmt = 1'b0;
      known_fmt  = 1'b1;
      nan_code   = '0;
      inf_code   = '0;

      case (s1_cmd_ff)
         FMT_HALF: begin
            norm_mag   = {ex_n, mant[22:13]} + 15'(mant[12]);
            dn_shift   = DN_SHIFT_HALF - expo;
            signed_fmt = 1'b1;
            nan_code   = NAN_HALF;
            inf_code   = INF_HALF;
         end
         FMT_F11: begin
            norm_mag = 15'({ex_n, mant[22:17]}) + 15'(mant[16]);
            dn_shift = DN_SHIFT_F11 - expo;
            nan_code = NAN_F11;
            inf_code = INF_F11;
         end
         FMT_F10: begin
            norm_mag = 15'({ex_n, mant[22:18]}) + 15'(mant[17]);
            dn_shift = DN_SHIFT_F10 - expo;
            nan_code = NAN_F10;
            inf_code = INF_F10;
         end
         default: begin
            known_fmt = 1'b0;
         end
      endcase

      // shifts of 24 or more clear everything, round bit included
      dn_bits = full >> dn_shift;
      dn_mag  = 15'(dn_bits[23:1]) + 15'(dn_bits[0]);
      sgn_bit = {signed_fmt & sign, 15'b0};

      if (!known_fmt) begin
         result_in = '0;
      end else if (expo == EXP_ZERO) begin
         result_in = sgn_bit;                   // zero or flushed denormal
      end else if (!signed_fmt && sign) begin
         result_in = '0;                        // negative into unsigned format
      end else if (expo == EXP_SPEC && mant != '0) begin
         result_in = nan_code;                  // NaN, no sign
      end else if (expo > EXP_MAX) begin
         result_in = inf_code | sgn_bit;        // overflow or infinity
      end else if (expo > EXP_OFFSET) begin
         result_in = sgn_bit | {1'b0, norm_mag};
      end else begin
         result_in = sgn_bit | {1'b0, dn_mag};  // carry here gives exponent 1
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff   <= fmt_type'(req_tuser);
         s1_value_ff <= req_tdata;
      end
      if (s1_adv) begin
         rsp_data_ff <= result_in;
      end
   end

   // ---------------- assertions ----------------
   // an accepted item always occupies the input stage next cycle
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted item missing from input stage");

   // an item blocked in the input stage keeps its payload
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_value_ff))
      else $error("input stage item lost while blocked");

   // unsigned formats never set bits above their width
   a_f11_width: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_cmd_ff == FMT_F11 |-> result_in[15:11] == '0)
      else $error("float11 result wider than 11 bits");

   a_f10_width: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_cmd_ff == FMT_F10 |-> result_in[15:10] == '0)
      else $error("float10 result wider than 10 bits");

   // both stages empty after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

endmodule
